FILE: hdl/pairwise_distance_3d_core_defines.svh
// Assertion macros used by the checker file of the distance core.
`ifndef PAIRWISE_DISTANCE_3D_CORE_DEFINES_SVH
`define PAIRWISE_DISTANCE_3D_CORE_DEFINES_SVH

// Check an expression at every clock edge outside reset.
`define PD3_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define PD3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pd3_pkg.sv
// Shared constants, types and codes of the 3D pairwise distance core.
`timescale 1ns / 1ps
`default_nettype none
package pd3_pkg;

	localparam int REF_DEPTH  = 32;
	localparam int COORD_BITS = 24;

	localparam int AXES    = 3;
	localparam int IDX_W   = 5;
	localparam int DIST_W  = 25;
	localparam int CFG_W   = 6;
	localparam int CFG_RESET = 32;

	localparam int ADDR_W  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
	localparam int POINT_W = AXES * COORD_BITS;
	localparam int RUN_MAX = (REF_DEPTH < 32) ? REF_DEPTH : 32;

	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int ACC_W   = SQ_W + 2;
	localparam int ROOT_W  = ACC_W / 2;
	localparam int SCNT_W  = $clog2(ROOT_W + 1);
	localparam int CMP_W   = (COORD_BITS > DIST_W) ? COORD_BITS : DIST_W;
	localparam int RCMP_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam int IN_DATA_W  = ((IDX_W + POINT_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((IDX_W + DIST_W + 7) / 8) * 8;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [2:0] PH_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_START,
		ST_SQRT,
		ST_OUT
	} pd3_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage
`default_nettype wire

FILE: hdl/pairwise_distance_3d_core.sv
// Top level of the 3D pairwise distance core: point store, sequencer and datapath.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: kind; tdata: slot, x, y, z
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: ref_index, distance; tlast
//  cfg       in   cfg_we                         cfg_wdata: ref_count
//
// A load item is written to the store as it is taken.
// A query item walks the stored points 0 .. count-1, each through a store read,
// square and sum over the three axes, a root start, the root steps, a hand-off and
// the output; the root unit works out one root bit per cycle.
// Reset clears control and sets ref_count to 32; the store has no clearing pass and
// holds garbage until loaded. A stalled result holds, and no item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_distance_3d_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// kind (bit 0)
	input  wire logic                              s_axis_tuser,
	// ref_slot [4:0], coord_x [28:5], coord_y [52:29], coord_z [76:53], zero fill
	input  wire logic [pd3_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// ref_index [4:0], distance [29:5], zero fill
	output logic      [pd3_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                                   m_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	input  wire logic                              cfg_we,
	input  wire logic [pd3_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int CB = pd3_pkg::COORD_BITS;

	pd3_pkg::pd3_state_t state_q, state_d;

	// configuration and run bookkeeping
	logic [pd3_pkg::CFG_W-1:0]   ref_count_q;
	logic [pd3_pkg::CFG_W-1:0]   run_len_q;
	logic [pd3_pkg::CFG_W-1:0]   count_c;
	logic [pd3_pkg::IDX_W-1:0]   idx_q;
	logic                        last_c;

	// query point
	logic signed [CB-1:0] qx_q, qy_q, qz_q;

	// input unpacking
	logic                        in_acc_c;
	logic [pd3_pkg::IDX_W-1:0]   in_slot_c;
	logic [pd3_pkg::POINT_W-1:0] in_point_c;
	logic                        st_we_c;
	logic                        st_re_c;
	logic [pd3_pkg::POINT_W-1:0] st_rdata;

	// square and sum datapath
	logic [2:0]                  ph_q;
	logic signed [CB-1:0]        ref_ax_c, q_ax_c;
	logic signed [CB:0]          d_c;
	logic [CB-1:0]               mag_c;
	logic                        over_c;
	logic [CB-1:0]               mag_q;
	logic [pd3_pkg::SQ_W-1:0]    sq_c;
	logic [pd3_pkg::SQ_W-1:0]    sq_q;
	logic [pd3_pkg::ACC_W-1:0]   acc_q;
	logic                        sat_q;

	// root unit
	logic                        sq_start_c;
	logic [pd3_pkg::ROOT_W-1:0]  root_c;
	pd3_pkg::sqrt_stat_t         sq_stat;
	logic [pd3_pkg::DIST_W-1:0]  dist_c;

	// output register
	logic [pd3_pkg::IDX_W-1:0]   out_idx_q;
	logic [pd3_pkg::DIST_W-1:0]  out_dist_q;
	logic                        out_last_q;

	assign in_acc_c   = s_axis_tvalid && s_axis_tready;
	assign in_slot_c  = s_axis_tdata[pd3_pkg::IDX_W-1:0];
	assign in_point_c = s_axis_tdata[pd3_pkg::IDX_W +: pd3_pkg::POINT_W];

	// clamp the configured count to what the store and index field can carry
	assign count_c = (ref_count_q > pd3_pkg::CFG_W'(pd3_pkg::RUN_MAX)) ?
		pd3_pkg::CFG_W'(pd3_pkg::RUN_MAX) : ref_count_q;
	assign last_c  = ((pd3_pkg::CFG_W'(idx_q) + pd3_pkg::CFG_W'(1)) == run_len_q);

	// drop loads that point beyond the store
	assign st_we_c = in_acc_c && (s_axis_tuser == pd3_pkg::KIND_LOAD) &&
		(int'(in_slot_c) < pd3_pkg::REF_DEPTH);

	pd3_ram #(
		.WIDTH(pd3_pkg::POINT_W),
		.DEPTH(pd3_pkg::REF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (st_we_c),
		.waddr (pd3_pkg::ADDR_W'(in_slot_c)),
		.wdata (in_point_c),
		.re    (st_re_c),
		.raddr (pd3_pkg::ADDR_W'(idx_q)),
		.rdata (st_rdata)
	);

	// pick the axis for this phase: x, then y, then z
	always_comb begin
		case (ph_q)
			3'd0: begin
				ref_ax_c = st_rdata[0 +: CB];
				q_ax_c   = qx_q;
			end
			3'd1: begin
				ref_ax_c = st_rdata[CB +: CB];
				q_ax_c   = qy_q;
			end
			default: begin
				ref_ax_c = st_rdata[2*CB +: CB];
				q_ax_c   = qz_q;
			end
		endcase
	end

	assign d_c    = {ref_ax_c[CB-1], ref_ax_c} - {q_ax_c[CB-1], q_ax_c};
	assign mag_c  = d_c[CB] ? CB'(-d_c) : d_c[CB-1:0];
	assign over_c = (pd3_pkg::CMP_W'(mag_c) > pd3_pkg::CMP_W'(pd3_pkg::DIST_MAX));
	assign sq_c   = pd3_pkg::SQ_W'(mag_q) * pd3_pkg::SQ_W'(mag_q);

	pd3_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start_c),
		.radicand (acc_q),
		.root     (root_c),
		.stat     (sq_stat)
	);

	// saturate a wide axis difference or an oversized root to the top code
	assign dist_c = sat_q ? pd3_pkg::DIST_MAX :
		(pd3_pkg::RCMP_W'(root_c) > pd3_pkg::RCMP_W'(pd3_pkg::DIST_MAX)) ?
			pd3_pkg::DIST_MAX : pd3_pkg::DIST_W'(pd3_pkg::RCMP_W'(root_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pd3_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and control strobes
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		st_re_c       = 1'b0;
		sq_start_c    = 1'b0;
		case (state_q)
			pd3_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && (s_axis_tuser == pd3_pkg::KIND_QUERY) &&
						(count_c != '0)) begin
					state_d = pd3_pkg::ST_READ;
				end
			end
			pd3_pkg::ST_READ: begin
				st_re_c = 1'b1;
				state_d = pd3_pkg::ST_MUL;
			end
			pd3_pkg::ST_MUL: begin
				if (ph_q == pd3_pkg::PH_LAST) begin
					state_d = pd3_pkg::ST_START;
				end
			end
			pd3_pkg::ST_START: begin
				sq_start_c = !sq_stat.busy;
				state_d    = pd3_pkg::ST_SQRT;
			end
			pd3_pkg::ST_SQRT: begin
				if (sq_stat.done) begin
					state_d = pd3_pkg::ST_OUT;
				end
			end
			pd3_pkg::ST_OUT: begin
				if (m_axis_tready) begin
					state_d = out_last_q ? pd3_pkg::ST_IDLE : pd3_pkg::ST_READ;
				end
			end
			default: begin
				state_d = pd3_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers: config, run length, index, phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= pd3_pkg::CFG_W'(pd3_pkg::CFG_RESET);
			run_len_q   <= '0;
			idx_q       <= '0;
			ph_q        <= '0;
		end else begin
			if (cfg_we) begin
				ref_count_q <= cfg_wdata;
			end
			if (state_q == pd3_pkg::ST_IDLE && in_acc_c &&
					s_axis_tuser == pd3_pkg::KIND_QUERY) begin
				run_len_q <= count_c;
				idx_q     <= '0;
			end
			if (state_q == pd3_pkg::ST_READ) begin
				ph_q <= '0;
			end else if (state_q == pd3_pkg::ST_MUL) begin
				ph_q <= ph_q + 3'd1;
			end
			// advance to the next stored point once the result is taken
			if (state_q == pd3_pkg::ST_OUT && m_axis_tready && !out_last_q) begin
				idx_q <= idx_q + pd3_pkg::IDX_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == pd3_pkg::ST_IDLE && in_acc_c &&
				s_axis_tuser == pd3_pkg::KIND_QUERY) begin
			qx_q <= in_point_c[0 +: CB];
			qy_q <= in_point_c[CB +: CB];
			qz_q <= in_point_c[2*CB +: CB];
		end
		if (state_q == pd3_pkg::ST_MUL) begin
			// three-deep pipe: magnitude, square, then sum
			if (ph_q < 3'd3) begin
				mag_q <= mag_c;
				sat_q <= (ph_q == 3'd0) ? over_c : (sat_q | over_c);
			end
			if (ph_q != 3'd0) begin
				sq_q <= sq_c;
			end
			if (ph_q == 3'd2) begin
				acc_q <= pd3_pkg::ACC_W'(sq_q);
			end else if (ph_q > 3'd2) begin
				acc_q <= acc_q + pd3_pkg::ACC_W'(sq_q);
			end
		end
		if (state_q == pd3_pkg::ST_SQRT && sq_stat.done) begin
			out_idx_q  <= idx_q;
			out_dist_q <= dist_c;
			out_last_q <= last_c;
		end
	end

	assign m_axis_tvalid = (state_q == pd3_pkg::ST_OUT);
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = pd3_pkg::OUT_DATA_W'({out_dist_q, out_idx_q});

endmodule
`default_nettype wire

FILE: hdl/pd3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pd3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/pd3_sqrt.sv
// Iterative floor square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pd3_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pd3_pkg::ACC_W-1:0]   radicand,
	output logic      [pd3_pkg::ROOT_W-1:0]  root,
	output pd3_pkg::sqrt_stat_t              stat
);

	localparam int T_W = pd3_pkg::ROOT_W + 3;

	logic                          busy_q;
	logic                          done_q;
	logic [pd3_pkg::SCNT_W-1:0]    cnt_q;
	logic [pd3_pkg::ACC_W-1:0]     rad_q;
	logic [pd3_pkg::ROOT_W:0]      rem_q;
	logic [pd3_pkg::ROOT_W-1:0]    root_q;

	logic [T_W-1:0] cat_c;
	logic [T_W-1:0] try_c;
	logic [T_W-1:0] diff_c;
	logic           ge_c;

	// bring down the next two radicand bits and test the next root bit
	assign cat_c  = {rem_q, rad_q[pd3_pkg::ACC_W-1 -: 2]};
	assign try_c  = {1'b0, root_q, 2'b01};
	assign diff_c = cat_c - try_c;
	assign ge_c   = (cat_c >= try_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= pd3_pkg::SCNT_W'(pd3_pkg::ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - pd3_pkg::SCNT_W'(1);
				if (cnt_q == pd3_pkg::SCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[pd3_pkg::ACC_W-3:0], 2'b00};
			rem_q  <= ge_c ? diff_c[pd3_pkg::ROOT_W:0] : cat_c[pd3_pkg::ROOT_W:0];
			root_q <= {root_q[pd3_pkg::ROOT_W-2:0], ge_c};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

FILE: hdl/pd3_chk.sv
// Port-level checker for the 3D pairwise distance core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "pairwise_distance_3d_core_defines.svh"
module pd3_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tready,
	input wire logic [pd3_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input wire logic                             m_axis_tlast,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready
);

	logic                            out_stall;
	logic                            out_take;
	logic [pd3_pkg::OUT_DATA_W:0]    out_word;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_take  = m_axis_tvalid && m_axis_tready;
	assign out_word  = {m_axis_tlast, m_axis_tdata};

	// a pending result blocks new items
	`PD3_ASSERT(a_no_in_while_out, !(m_axis_tvalid && s_axis_tready), "ready while result pending")

	// a stalled result holds its payload
	`PD3_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled result changed")

	// a run keeps going after a non-final result
	`PD3_ASSERT_NEXT(a_run_busy, out_take && !m_axis_tlast, !s_axis_tready, "idle in mid run")

	// the final result of a run frees the input
	`PD3_ASSERT_NEXT(a_run_done, out_take && m_axis_tlast, s_axis_tready, "not ready after last")

endmodule

bind pairwise_distance_3d_core pd3_chk u_pd3_chk (.*);
`default_nettype wire

FILE: tb/sv/pairwise_distance_3d_core_tb.sv
// Self-checking testbench for the 3D pairwise distance core.
`timescale 1ns / 1ps
module pairwise_distance_3d_core_tb;
	import pd3_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	// covers a load and a zero-count query, with margin
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 600;
	localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_MIN = -(1 << (COORD_BITS - 1));

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic kind;
		logic [IDX_W-1:0] slot;
		coord_t x;
		coord_t y;
		coord_t z;
	} point_item_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} ref_point_t;

	typedef struct packed {
		logic [IDX_W-1:0] ref_index;
		logic [DIST_W-1:0] distance;
		logic run_end;
	} dist_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tuser = 1'b0;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// stimulus waiting for the driver, and distances still owed by the core
	point_item_t stim_items[$];
	dist_result_t owed_dists[$];

	// predictor state: its own copy of the point store and of ref_count
	ref_point_t ref_store[REF_DEPTH];
	logic [CFG_W-1:0] run_len = CFG_W'(CFG_RESET);

	// generator-side record of which store entries hold a point
	logic [REF_DEPTH-1:0] slot_loaded = '0;

	point_item_t drv_item = '0;
	logic item_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_armed = 1'b0;
	logic hold_used = 1'b0;
	int hold_left = 0;
	int mismatches = 0;
	int cycles = 0;

	pairwise_distance_3d_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Bit-serial floor square root, two bits of the operand per step.
	function automatic logic [63:0] int_sqrt(input logic [63:0] val);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bitv;
		rem = val;
		root = '0;
		bitv = 64'h1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] axis_sq(input coord_t a, input coord_t b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		return d * d;
	endfunction

	function automatic logic [DIST_W-1:0] point_distance(input ref_point_t r,
			input point_item_t q);
		logic [63:0] root;
		root = int_sqrt(axis_sq(r.x, q.x) + axis_sq(r.y, q.y) + axis_sq(r.z, q.z));
		// saturate; unreachable at 24-bit coordinates but kept for wider builds
		if (root > 64'(DIST_MAX))
			return DIST_MAX;
		return root[DIST_W-1:0];
	endfunction

	function automatic int run_points();
		return (int'(run_len) > RUN_MAX) ? RUN_MAX : int'(run_len);
	endfunction

	// Update the store on a load; queue one distance per compared point on a query.
	task automatic apply_item(input point_item_t it);
		int n;
		dist_result_t res;
		if (it.kind == KIND_LOAD) begin
			if (int'(it.slot) < REF_DEPTH)
				ref_store[it.slot] = '{x: it.x, y: it.y, z: it.z};
		end else begin
			n = run_points();
			for (int i = 0; i < n; i++) begin
				res.ref_index = i[IDX_W-1:0];
				res.distance = point_distance(ref_store[i], it);
				res.run_end = (i == n - 1);
				owed_dists.push_back(res);
			end
		end
	endtask

	// Drive the input side at the falling edge; hold an offered item until taken.
	always @(negedge clk) begin
		point_item_t nxt;
		logic offer;
		nxt = drv_item;
		offer = s_axis_tvalid;
		if (!arst_n) begin
			offer = 1'b0;
		end else if (!s_axis_tvalid || item_taken) begin
			offer = 1'b0;
			if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = stim_items.pop_front();
				offer = 1'b1;
			end
		end
		drv_item <= nxt;
		s_axis_tvalid <= offer;
		s_axis_tuser <= nxt.kind;
		s_axis_tdata <= {{(IN_DATA_W - IDX_W - 3 * COORD_BITS){1'b0}},
			nxt.z, nxt.y, nxt.x, nxt.slot};
	end

	// Drive tready; once armed, hold off for a long stretch on the first result
	// so the core fills up and stalls its input while items keep being offered.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_armed && !hold_used && m_axis_tvalid) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sample both handshakes at the rising edge: predict on input, check on output.
	always @(posedge clk) begin
		dist_result_t want;
		item_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			apply_item(drv_item);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (owed_dists.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual index %0d distance %0d",
					$realtime, m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W +: DIST_W]);
				mismatches++;
			end else begin
				want = owed_dists.pop_front();
				if (m_axis_tdata[IDX_W-1:0] !== want.ref_index) begin
					$display("%0t: ref_index mismatch, expected %0d, actual %0d",
						$realtime, want.ref_index, m_axis_tdata[IDX_W-1:0]);
					mismatches++;
				end
				if (m_axis_tdata[IDX_W +: DIST_W] !== want.distance) begin
					$display("%0t: distance mismatch (index %0d), expected %0d, actual %0d",
						$realtime, want.ref_index, want.distance,
						m_axis_tdata[IDX_W +: DIST_W]);
					mismatches++;
				end
				if (m_axis_tlast !== want.run_end) begin
					$display("%0t: tlast mismatch (index %0d), expected %0b, actual %0b",
						$realtime, want.ref_index, want.run_end, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	// Bound the run in case the core hangs or drops results.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still owed", $realtime, owed_dists.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Mix extremes, zero, small offsets and full-range values.
	function automatic int rand_coord();
		int r;
		case ($urandom_range(9))
			0: r = COORD_MAX;
			1: r = COORD_MIN;
			2: r = 0;
			3, 4, 5: r = int'($urandom_range(8191)) - 4096;
			default: r = int'($urandom());
		endcase
		return r;
	endfunction

	task automatic push_item(input logic kind, input int slot, input int x, input int y,
			input int z);
		point_item_t it;
		it.kind = kind;
		it.slot = slot[IDX_W-1:0];
		it.x = x[COORD_BITS-1:0];
		it.y = y[COORD_BITS-1:0];
		it.z = z[COORD_BITS-1:0];
		stim_items.push_back(it);
		if (kind == KIND_LOAD)
			slot_loaded[it.slot] = 1'b1;
	endtask

	// Lowest entry a query would read that holds no point yet, or -1.
	function automatic int missing_slot();
		for (int i = 0; i < run_points(); i++)
			if (!slot_loaded[i])
				return i;
		return -1;
	endfunction

	// Mostly queries over loaded entries; fill a gap with a load before querying it.
	task automatic random_items(input int count);
		int gap;
		for (int i = 0; i < count; i++) begin
			gap = missing_slot();
			if ($urandom_range(99) < 30)
				push_item(KIND_LOAD, $urandom_range(31), rand_coord(), rand_coord(),
					rand_coord());
			else if (gap >= 0)
				push_item(KIND_LOAD, gap, rand_coord(), rand_coord(), rand_coord());
			else
				push_item(KIND_QUERY, $urandom_range(31), rand_coord(), rand_coord(),
					rand_coord());
		end
	endtask

	// Block idle only once every item is taken and every distance has arrived.
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (stim_items.size() != 0 || s_axis_tvalid || owed_dists.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_run_len(input int value);
		@(negedge clk);
		cfg_wdata <= value[CFG_W-1:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		run_len = value[CFG_W-1:0];
	endtask

	initial begin
		for (int i = 0; i < REF_DEPTH; i++)
			ref_store[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 15;
		recv_idle_pct = 58;

		// zero count: queries give nothing; seed the store with extremes
		write_run_len(0);
		push_item(KIND_QUERY, 0, 0, 0, 0);
		push_item(KIND_QUERY, 31, COORD_MAX, COORD_MAX, COORD_MAX);
		push_item(KIND_LOAD, 0, COORD_MAX, COORD_MAX, COORD_MAX);
		push_item(KIND_LOAD, 31, COORD_MIN, COORD_MIN, COORD_MIN);
		push_item(KIND_LOAD, 21, rand_coord(), rand_coord(), rand_coord());
		push_item(KIND_LOAD, 10, rand_coord(), rand_coord(), rand_coord());
		wait_quiet();

		// single-point runs: largest distance, zero, one LSB, mixed signs
		write_run_len(1);
		push_item(KIND_QUERY, 0, COORD_MIN, COORD_MIN, COORD_MIN);
		push_item(KIND_QUERY, 7, COORD_MAX, COORD_MAX, COORD_MAX);
		push_item(KIND_QUERY, 0, COORD_MAX, COORD_MIN, 0);
		push_item(KIND_LOAD, 0, 0, 0, 0);
		push_item(KIND_QUERY, 0, 0, 0, 0);
		push_item(KIND_QUERY, 0, 1, 0, 0);
		push_item(KIND_QUERY, 0, -1, -1, -1);
		push_item(KIND_QUERY, 0, 3, 4, 0);
		push_item(KIND_LOAD, 0, COORD_MIN, COORD_MAX, COORD_MIN);
		push_item(KIND_QUERY, 0, COORD_MAX, COORD_MIN, COORD_MAX);
		wait_quiet();

		// full runs, with one long output stall
		write_run_len(32);
		hold_armed = 1'b1;
		random_items(100);
		wait_quiet();

		// count above depth clamps to a full run; swap the idle rates
		send_idle_pct = 58;
		recv_idle_pct = 15;
		write_run_len(63);
		random_items(100);
		wait_quiet();

		// back to back on both sides with a partial run
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_run_len($urandom_range(31, 2));
		random_items(100);
		wait_quiet();

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
